### hw/rtl/mbd_pkg.sv
// ----------------------------------------------------------------------------
// mbd_pkg: shared types and constants of the multipart boundary deframer
// Register indexes, the beat handed from the window to the parser and the
// header tail tracking type.
// ----------------------------------------------------------------------------
package mbd_pkg;

    localparam int unsigned BND_BYTES = 32;

    localparam logic [2:0] CFG_ENABLE = 3'd0;
    localparam logic [2:0] CFG_LENGTH = 3'd1;
    localparam logic [2:0] CFG_WORD0  = 3'd2;
    localparam logic [2:0] CFG_WORD1  = 3'd3;
    localparam logic [2:0] CFG_WORD2  = 3'd4;
    localparam logic [2:0] CFG_WORD3  = 3'd5;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // One accepted byte as seen by the parser.
    typedef struct packed {
        logic       step;   // byte accepted while streaming
        logic       have;   // a byte left the window
        logic       match;  // window holds the boundary after this byte
        logic [7:0] data;   // byte that left the window
    } t_pop;

    typedef struct packed {
        logic [23:0] tail;
        logic [1:0]  fill;
        logic        done;
    } t_tail;

endpackage

### hw/rtl/mbd_cell.sv
// ----------------------------------------------------------------------------
// mbd_cell: one byte of the boundary window
// Holds one byte, takes its neighbor's byte on every shift and compares the
// byte it is about to take with its expected boundary byte.
// ----------------------------------------------------------------------------
module mbd_cell
    import mbd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_expect,
    output logic [7:0] o_byte,
    output logic       o_hit
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = (i_byte == i_expect);

endmodule

### hw/rtl/mbd_parser.sv
// ----------------------------------------------------------------------------
// mbd_parser: part structure tracking
// Follows the bytes that leave the window: drops the CR LF after a boundary,
// watches for the CR LF CR LF that ends the headers and flags the body.
// ----------------------------------------------------------------------------
module mbd_parser
    import mbd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_clear,
    input  t_pop i_pop,
    output logic o_body
);

    typedef enum logic [3:0] {
        PH_SEEK = 4'b0001,
        PH_CRLF = 4'b0010,
        PH_HEAD = 4'b0100,
        PH_BODY = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_skip, n_skip;
    logic [23:0] r_tail, n_tail;
    logic [1:0]  r_tail_fill, n_tail_fill;

    function automatic t_tail feed(input t_tail t, input logic [7:0] b);
        t_tail res;
        if (t.fill == 2'd3 && t.tail == {CHAR_CR, CHAR_LF, CHAR_CR} && b == CHAR_LF) begin
            res.tail = 24'd0;
            res.fill = 2'd0;
            res.done = 1'b1;
        end else begin
            res.tail = {t.tail[15:0], b};
            res.fill = (t.fill == 2'd3) ? 2'd3 : 2'(t.fill + 2'd1);
            res.done = 1'b0;
        end
        return res;
    endfunction

    always_comb begin
        t_tail cur;
        t_tail f1;
        t_tail f2;
        n_phase     = r_phase;
        n_skip      = r_skip;
        n_tail      = r_tail;
        n_tail_fill = r_tail_fill;
        cur.tail    = r_tail;
        cur.fill    = r_tail_fill;
        cur.done    = 1'b0;
        f1          = cur;
        f2          = cur;
        if (i_pop.step && i_pop.have) begin
            case (r_phase)
                PH_CRLF: begin
                    if (!r_skip) begin
                        if (i_pop.data == CHAR_CR) begin
                            n_skip = 1'b1;
                        end else begin
                            f1          = feed(cur, i_pop.data);
                            n_tail      = f1.tail;
                            n_tail_fill = f1.fill;
                            n_phase     = f1.done ? PH_BODY : PH_HEAD;
                        end
                    end else begin
                        n_skip  = 1'b0;
                        n_phase = PH_HEAD;
                        if (i_pop.data != CHAR_LF) begin
                            // The held CR was a header byte after all.
                            f1          = feed(cur, CHAR_CR);
                            f2          = feed(f1, i_pop.data);
                            n_tail      = f2.tail;
                            n_tail_fill = f2.fill;
                            n_phase     = f2.done ? PH_BODY : PH_HEAD;
                        end
                    end
                end
                PH_HEAD: begin
                    f1          = feed(cur, i_pop.data);
                    n_tail      = f1.tail;
                    n_tail_fill = f1.fill;
                    if (f1.done) begin
                        n_phase = PH_BODY;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_pop.step && i_pop.match) begin
            n_phase     = PH_CRLF;
            n_skip      = 1'b0;
            n_tail      = 24'd0;
            n_tail_fill = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_phase     <= PH_SEEK;
            r_skip      <= 1'b0;
            r_tail      <= 24'd0;
            r_tail_fill <= 2'd0;
        end else begin
            r_phase     <= n_phase;
            r_skip      <= n_skip;
            r_tail      <= n_tail;
            r_tail_fill <= n_tail_fill;
        end
    end

    assign o_body = (r_phase == PH_BODY);

endmodule

### hw/rtl/multipart_boundary_deframer.sv
// ----------------------------------------------------------------------------
// multipart_boundary_deframer: multipart body extraction by boundary match
// Throughput: one byte per cycle without output stall, set by the window
// shift line of byte cells. Body bytes wait for boundary_length more bytes.
// Reset (synchronous, active low) clears the registers, fill count and parse;
// window bytes are not cleared, the fill count masks them.
// ----------------------------------------------------------------------------
module multipart_boundary_deframer
    import mbd_pkg::*;
#(
    parameter int unsigned MAX_BOUNDARY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_body_byte,
    output logic        o_frame_last
);

    localparam int unsigned NCELL   = (MAX_BOUNDARY < BND_BYTES) ? MAX_BOUNDARY : BND_BYTES;
    localparam int unsigned CW      = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam logic [5:0]  LEN_MAX = 6'(NCELL);

    logic                 r_enable;
    logic [5:0]           r_blen;
    logic [4*64-1:0]      r_bnd;
    logic [5:0]           r_fill, n_fill;
    logic                 r_out_valid;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic [5:0]           w_len;
    logic                 w_accept;
    logic                 w_active;
    logic                 w_step;
    logic                 w_cfg_clear;
    logic                 w_clear;
    logic                 w_have;
    logic                 w_full_next;
    logic                 w_match;
    logic                 w_body;
    logic                 w_emit;
    logic [7:0]           w_popped;
    logic [5:0]           w_last_idx;
    logic [7:0]           w_cell_in   [NCELL];
    logic [7:0]           w_cell_byte [NCELL];
    logic [NCELL-1:0]     w_hit_ok;
    t_pop                 w_pop;

    assign w_len       = (r_blen > LEN_MAX) ? LEN_MAX : r_blen;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_active    = r_enable && (w_len != 6'd0);
    assign w_step      = w_accept && w_active;
    assign w_cfg_clear = i_cfg_we && (((i_cfg_index == CFG_ENABLE) && !i_cfg_data[0])
                         || (i_cfg_index == CFG_LENGTH) || (i_cfg_index == CFG_WORD0)
                         || (i_cfg_index == CFG_WORD1) || (i_cfg_index == CFG_WORD2)
                         || (i_cfg_index == CFG_WORD3));
    assign w_clear     = w_cfg_clear || (w_accept && !w_active);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_blen   <= 6'd0;
            r_bnd    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_LENGTH: r_blen <= i_cfg_data[5:0];
                CFG_WORD0:  r_bnd[0*64 +: 64] <= i_cfg_data;
                CFG_WORD1:  r_bnd[1*64 +: 64] <= i_cfg_data;
                CFG_WORD2:  r_bnd[2*64 +: 64] <= i_cfg_data;
                CFG_WORD3:  r_bnd[3*64 +: 64] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Cell 0 holds the newest byte; cell j is compared with boundary byte
    // len-1-j, so the oldest byte in the window meets boundary byte zero.
    genvar j;
    generate
        for (j = 0; j < NCELL; j++) begin : g_cell
            logic [5:0] w_idx;
            logic [7:0] w_expect;
            logic       w_hit;

            assign w_idx    = 6'(w_len - 6'd1 - 6'(j));
            assign w_expect = r_bnd[w_idx[4:0]*8 +: 8];

            if (j == 0) begin : g_head
                assign w_cell_in[j] = i_data_byte;
            end else begin : g_link
                assign w_cell_in[j] = w_cell_byte[j-1];
            end

            mbd_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (w_step),
                .i_byte   (w_cell_in[j]),
                .i_expect (w_expect),
                .o_byte   (w_cell_byte[j]),
                .o_hit    (w_hit)
            );

            assign w_hit_ok[j] = w_hit || (6'(j) >= w_len);
        end
    endgenerate

    assign w_last_idx  = 6'(w_len - 6'd1);
    assign w_popped    = w_cell_byte[w_last_idx[CW-1:0]];
    assign w_have      = (r_fill == w_len);
    assign w_full_next = w_have || (6'(r_fill + 6'd1) == w_len);
    assign w_match     = w_full_next && (&w_hit_ok);

    always_comb begin
        n_fill = r_fill;
        if (w_step && !w_have) begin
            n_fill = 6'(r_fill + 6'd1);
        end
        if (w_step && w_match) begin
            n_fill = 6'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_fill <= 6'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign w_pop.step  = w_step;
    assign w_pop.have  = w_have;
    assign w_pop.match = w_match;
    assign w_pop.data  = w_popped;

    mbd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_pop   (w_pop),
        .o_body  (w_body)
    );

    assign w_emit = w_step && w_have && w_body;

    // Output register; a new beat is only taken when it is free or draining.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= w_popped;
            r_out_last <= w_match;
        end
    end

    assign o_in_stall   = r_out_valid && i_out_stall;
    assign o_out_valid  = r_out_valid;
    assign o_body_byte  = r_out_byte;
    assign o_frame_last = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= w_len) || !w_active)
        else $error("window fill exceeds boundary length");

    a_match_leaves_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_match) |=> !w_body)
        else $error("parser in body right after a boundary match");

    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with an empty output register");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> !(r_out_valid && i_out_stall))
        else $error("beat emitted over a stalled result");

endmodule

### bench/tb_multipart_boundary_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multipart_boundary_deframer: self-checking bench of the boundary deframer
// A short directed sequence walks the open cases of the parse with a one byte
// boundary. Random phases then reprogram the boundary and stream multipart
// traffic with random content and broken parts. Every body beat is checked
// against a cycle-free model of the window match and the part parse.
// ----------------------------------------------------------------------------
module tb_multipart_boundary_deframer;
    import mbd_pkg::*;

    localparam int unsigned MAX_BND        = 32;
    localparam int unsigned CLK_HALF       = 4;
    localparam int unsigned RESET_CYCLES   = 7;
    localparam int unsigned ITEMS          = 1000;
    localparam int unsigned STALL_PCT      = 9;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned WATCHDOG_LIMIT = 20000;

    // Indexes that decode to no register.
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    typedef enum logic [1:0] {
        SEEK_FIRST,
        SKIP_CRLF,
        IN_HEADERS,
        IN_BODY
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] body;
        logic       last;
    } t_body_beat;

    class t_body_beat_predictor;
        bit           cfg_enable;
        logic [5:0]   cfg_length;
        logic [63:0]  cfg_word [4];
        logic [7:0]   window [BND_BYTES + 1];
        int unsigned  held;
        t_parse_phase phase;
        bit           cr_pending;
        logic [23:0]  tail;
        int unsigned  tail_count;
        t_body_beat   pending_beats [$];
        int unsigned  errors;

        function new();
            cfg_enable = 1'b0;
            cfg_length = '0;
            foreach (cfg_word[w]) cfg_word[w] = '0;
            errors = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            foreach (window[k]) window[k] = '0;
            held       = 0;
            phase      = SEEK_FIRST;
            cr_pending = 1'b0;
            tail       = '0;
            tail_count = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [63:0] data);
            case (index)
                CFG_ENABLE: begin
                    cfg_enable = data[0];
                    if (!cfg_enable) clear_parse();
                end
                CFG_LENGTH: begin
                    cfg_length = data[5:0];
                    clear_parse();
                end
                CFG_WORD0, CFG_WORD1, CFG_WORD2, CFG_WORD3: begin
                    cfg_word[index - CFG_WORD0] = data;
                    clear_parse();
                end
                default: ;
            endcase
        endfunction

        function void feed_header(logic [7:0] b);
            if (tail_count == 3 && tail == {CHAR_CR, CHAR_LF, CHAR_CR} && b == CHAR_LF) begin
                phase      = IN_BODY;
                tail       = '0;
                tail_count = 0;
            end else begin
                tail = {tail[15:0], b};
                if (tail_count < 3) tail_count++;
            end
        endfunction

        // A byte that left the window without being part of a boundary.
        function void retire(logic [7:0] b);
            case (phase)
                SKIP_CRLF: begin
                    if (!cr_pending) begin
                        if (b == CHAR_CR) begin
                            cr_pending = 1'b1;
                        end else begin
                            phase = IN_HEADERS;
                            feed_header(b);
                        end
                    end else begin
                        cr_pending = 1'b0;
                        phase      = IN_HEADERS;
                        if (b != CHAR_LF) begin
                            feed_header(CHAR_CR);
                            feed_header(b);
                        end
                    end
                end
                IN_HEADERS: feed_header(b);
                default: ;
            endcase
        endfunction

        function void accept_byte(logic [7:0] b);
            int unsigned len;
            int unsigned i;
            logic [7:0]  popped;
            bit          have;
            bit          hit;
            t_body_beat  beat;
            len = (cfg_length > MAX_BND) ? MAX_BND : cfg_length;
            if (!cfg_enable || len == 0) begin
                clear_parse();
                return;
            end
            if (held > len) held = len;
            have   = 1'b0;
            hit    = 1'b0;
            popped = '0;
            if (held == len) begin
                popped = window[0];
                have   = 1'b1;
                for (i = 1; i < held; i++) window[i - 1] = window[i];
                held--;
            end
            window[held] = b;
            held++;
            if (held == len) begin
                hit = 1'b1;
                for (i = 0; i < len; i++) begin
                    if (window[i] != cfg_word[i >> 3][8 * (i & 7) +: 8]) hit = 1'b0;
                end
            end
            if (have) begin
                if (phase == IN_BODY) begin
                    beat.body = popped;
                    beat.last = hit;
                    pending_beats.push_back(beat);
                end else begin
                    retire(popped);
                end
            end
            if (hit) begin
                clear_parse();
                phase = SKIP_CRLF;
            end
        endfunction

        function void check_beat(logic [7:0] body, logic last);
            t_body_beat want;
            if (pending_beats.size() == 0) begin
                $error("body beat 0x%02h (frame_last %0b) arrived with none expected",
                       body, last);
                errors++;
                return;
            end
            want = pending_beats.pop_front();
            if (body !== want.body) begin
                $error("body_byte: expected 0x%02h, got 0x%02h", want.body, body);
                errors++;
            end
            if (last !== want.last) begin
                $error("frame_last: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_beats.size();
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_body_byte;
    logic        o_frame_last;

    t_body_beat_predictor predictor;
    logic [7:0]  boundary [BND_BYTES];
    bit          calm     = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned quiet_cycles = 0;

    multipart_boundary_deframer #(
        .MAX_BOUNDARY(MAX_BND)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_body_byte (o_body_byte),
        .o_frame_last(o_frame_last)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Config writes, input beats and output beats are seen in that order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) predictor.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) predictor.accept_byte(i_data_byte);
            if (o_out_valid && !i_out_stall) predictor.check_beat(o_body_byte, o_frame_last);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("multipart_boundary_deframer test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Output side: random stalls, none while calm, or one long hold-off when requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < STALL_PCT);
            end
        end
    end

    task automatic cfg_write(input logic [2:0] index, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Writes every register; the upper bits of enable and length carry noise.
    task automatic program_regs(input bit en, input logic [5:0] len, input bit spare);
        logic [63:0] data;
        int          w;
        int          j;
        if (spare) begin
            cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
        end
        data      = {$urandom, $urandom};
        data[5:0] = len;
        cfg_write(CFG_LENGTH, data);
        for (w = 0; w < 4; w++) begin
            for (j = 0; j < 8; j++) data[8 * j +: 8] = boundary[8 * w + j];
            cfg_write(3'(CFG_WORD0 + w), data);
        end
        data    = {$urandom, $urandom};
        data[0] = en;
        cfg_write(CFG_ENABLE, data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_stream(input logic [7:0] beats [$]);
        foreach (beats[k]) begin
            if (!calm) begin
                while ($urandom_range(0, 99) < STALL_PCT) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_in_valid  <= 1'b1;
            i_data_byte <= beats[k];
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
        end
        i_in_valid <= 1'b0;
    endtask

    // Drain every expected beat, then let any byte still in flight settle.
    task automatic wait_idle();
        while (predictor.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0]  byte_stream [$];
        string       fallback;
        int unsigned rand_items;
        int unsigned phase_idx;
        int unsigned kind;
        int unsigned form;
        int unsigned eff;
        int unsigned n;
        int unsigned i;
        bit          en;
        bit          firm;
        logic [5:0]  len;

        predictor  = new();
        fallback   = "--boundarydonotcross";
        rand_items = 0;
        phase_idx  = 0;
        foreach (boundary[k]) boundary[k] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset the block is disabled and must drop everything.
        byte_stream = {8'hFF};
        send_stream(byte_stream);
        wait_idle();
        program_regs(1'b1, 6'd0, 1'b1);
        byte_stream = {8'h00};
        send_stream(byte_stream);
        wait_idle();

        // One dash as boundary: a full part, an empty body, a part without
        // a header end, and a lone CR before the headers with a cut-off body.
        boundary[0] = 8'h2D;
        program_regs(1'b1, 6'd1, 1'b0);
        byte_stream = {8'h2D, CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF,
                       8'h00, 8'hFF, 8'h2D,
                       CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF, 8'h2D,
                       8'h58, 8'h59, 8'h2D,
                       CHAR_CR, 8'h5A, CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF, 8'h51};
        send_stream(byte_stream);

        while (rand_items < ITEMS) begin
            kind = $urandom_range(0, 9);
            en   = 1'b1;
            for (i = 0; i < BND_BYTES; i++) boundary[i] = 8'($urandom);
            case (kind)
                0: begin
                    len = 6'd20;
                    for (i = 0; i < 20; i++) boundary[i] = fallback[i];
                end
                1: len = 6'($urandom_range(32, 63));
                2: len = 6'($urandom_range(1, 2));
                3: begin
                    len = 6'($urandom_range(1, 63));
                    if ($urandom_range(0, 1)) en = 1'b0;
                    else len = 6'd0;
                end
                default: begin
                    len = 6'($urandom_range(3, 16));
                    boundary[0] = 8'h2D;
                    boundary[1] = 8'h2D;
                end
            endcase
            if (phase_idx == 0) begin
                en  = 1'b1;
                len = 6'd63;
            end else if (phase_idx == 1) begin
                en  = 1'b1;
                len = 6'd32;
            end else if ((phase_idx == 2 || phase_idx == 4) && (len == 0 || !en)) begin
                en  = 1'b1;
                len = 6'd8;
            end
            eff  = (len > MAX_BND) ? MAX_BND : len;
            calm = (phase_idx == 4);
            // The hold-off phase always carries complete parts with bodies.
            firm = (phase_idx == 2);

            wait_idle();
            program_regs(en, len, $urandom_range(0, 3) == 0);

            byte_stream.delete();
            if (!en || eff == 0) begin
                repeat ($urandom_range(10, 20)) byte_stream.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(0, 8)) byte_stream.push_back(8'($urandom));
                repeat ((phase_idx == 2 || phase_idx == 4) ? 4 : $urandom_range(1, 4)) begin
                    for (i = 0; i < eff; i++) byte_stream.push_back(boundary[i]);
                    form = firm ? 0 : $urandom_range(0, 9);
                    if (form <= 6) begin
                        if (firm || $urandom_range(0, 7) != 0) begin
                            byte_stream.push_back(CHAR_CR);
                            byte_stream.push_back(CHAR_LF);
                        end
                        n = $urandom_range(0, 2);
                        repeat (n) begin
                            repeat ($urandom_range(1, 12)) begin
                                byte_stream.push_back(8'($urandom_range(32, 126)));
                            end
                            byte_stream.push_back(CHAR_CR);
                            byte_stream.push_back(CHAR_LF);
                        end
                        repeat ((n == 0) ? 2 : 1) begin
                            byte_stream.push_back(CHAR_CR);
                            byte_stream.push_back(CHAR_LF);
                        end
                        n = (!firm && $urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
                        repeat (n) byte_stream.push_back(8'($urandom));
                    end else if (form == 7) begin
                        repeat ($urandom_range(0, 20)) begin
                            byte_stream.push_back(8'($urandom_range(32, 126)));
                        end
                    end else if (form == 8) begin
                        byte_stream.push_back(CHAR_CR);
                        byte_stream.push_back(8'($urandom));
                        byte_stream.push_back(CHAR_CR);
                        byte_stream.push_back(CHAR_LF);
                        byte_stream.push_back(CHAR_CR);
                        byte_stream.push_back(CHAR_LF);
                        repeat ($urandom_range(1, 10)) byte_stream.push_back(8'($urandom));
                    end else begin
                        // Noise rich in CR and LF to hit partial header ends.
                        repeat ($urandom_range(0, 30)) begin
                            if ($urandom_range(0, 2) == 0)
                                byte_stream.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
                            else
                                byte_stream.push_back(8'($urandom));
                        end
                    end
                end
                if ($urandom_range(0, 4) != 0) begin
                    for (i = 0; i < eff; i++) byte_stream.push_back(boundary[i]);
                end else begin
                    repeat ($urandom_range(1, 6)) byte_stream.push_back(8'($urandom));
                end
                rand_items += byte_stream.size();
            end

            // The output side holds off while the sender keeps offering beats.
            if (phase_idx == 2) hold_req = 1'b1;
            send_stream(byte_stream);
            phase_idx++;
        end

        calm = 1'b0;
        wait_idle();
        if (predictor.errors == 0 && predictor.pending() == 0) begin
            $display("multipart_boundary_deframer test passed");
        end else begin
            $display("multipart_boundary_deframer test failed");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/mbd_pkg.sv
hw/rtl/mbd_cell.sv
hw/rtl/mbd_parser.sv
hw/rtl/multipart_boundary_deframer.sv
bench/tb_multipart_boundary_deframer.sv
